[rtl/bmf_pkg.sv]
`default_nettype none
package bmf_pkg;

	localparam int PIX_W       = 8;
	localparam int ROW_DEPTH   = 32;
	localparam int COL_W       = 5;
	localparam int ROW_W       = 12;
	localparam int SLOT_W      = 3;
	localparam int DEF_WIDTH   = 8;
	localparam int DEF_HEIGHT  = 8;
	localparam int DEF_WINDOW  = 5;
	localparam int QUEUE_DEPTH = 4;

	// one output position to compute
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] slot;
		logic              run_last;
		logic              frame_last;
	} job_t;

	// line store write request
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] slot;
		logic [COL_W-1:0]  addr;
		logic [PIX_W-1:0]  data;
	} wr_t;

endpackage
`default_nettype wire

[rtl/bmf_ram.sv]
`default_nettype none
module bmf_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/bmf_queue.sv]
`default_nettype none
module bmf_queue #(
	parameter int DEPTH = bmf_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bmf_pkg::job_t din,
	input  logic          pop,
	output bmf_pkg::job_t dout,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bmf_pkg::job_t     slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign dout  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/bmf_front.sv]
`default_nettype none
module bmf_front #(
	parameter int WIDTH  = bmf_pkg::DEF_WIDTH,
	parameter int HEIGHT = bmf_pkg::DEF_HEIGHT,
	parameter int WINDOW = bmf_pkg::DEF_WINDOW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  logic [bmf_pkg::PIX_W-1:0] pix_data,
	input  logic                      back_busy,
	input  logic                      queue_empty,
	input  logic                      queue_full,
	output bmf_pkg::job_t             job,
	output logic                      job_push,
	output bmf_pkg::wr_t              wr
);

	localparam int AHEAD = WINDOW - 1 - WINDOW / 2;
	localparam int IR_W  = $clog2(HEIGHT);
	localparam int OR_W  = $clog2(HEIGHT + 1);
	localparam int C_W   = $clog2(WIDTH);
	localparam int SW    = $clog2(WINDOW);

	typedef enum logic [1:0] {
		F_ACCEPT = 2'b01,
		F_GEN    = 2'b10
	} fstate_t;

	fstate_t         state_q;
	logic [IR_W-1:0] in_row_q;
	logic [C_W-1:0]  in_col_q;
	logic [SW-1:0]   in_slot_q;
	logic [OR_W-1:0] out_row_q;
	logic [C_W-1:0]  out_col_q;
	logic [SW-1:0]   out_slot_q;

	logic            accept;
	logic            emit_cur, emit_nxt, row_wrap;
	logic [OR_W-1:0] nxt_row;
	logic [C_W-1:0]  nxt_col;

	// output (r,c) is ready once pixel (min(r+ahead,h-1), min(c+ahead,w-1)) is in
	function automatic logic fits(input logic [OR_W-1:0] r, input logic [C_W-1:0] c,
			input logic [IR_W-1:0] ir, input logic [C_W-1:0] ic);
		logic [OR_W:0] ra;
		logic [C_W:0]  ca;
		logic [OR_W:0] irx;
		logic [C_W:0]  icx;
		ra  = {1'b0, r} + (OR_W+1)'(AHEAD);
		ca  = {1'b0, c} + (C_W+1)'(AHEAD);
		irx = (OR_W+1)'(ir);
		icx = {1'b0, ic};
		if (ra > (OR_W+1)'(HEIGHT - 1)) begin
			ra = (OR_W+1)'(HEIGHT - 1);
		end
		if (ca > (C_W+1)'(WIDTH - 1)) begin
			ca = (C_W+1)'(WIDTH - 1);
		end
		return (r < OR_W'(HEIGHT)) && ((ra < irx) || ((ra == irx) && (ca <= icx)));
	endfunction

	assign pix_ready = (state_q == F_ACCEPT) && queue_empty && !back_busy;
	assign accept    = pix_valid && pix_ready;

	assign row_wrap = (out_col_q == C_W'(WIDTH - 1));
	assign nxt_col  = row_wrap ? '0 : out_col_q + 1'b1;
	assign nxt_row  = row_wrap ? out_row_q + 1'b1 : out_row_q;
	assign emit_cur = fits(out_row_q, out_col_q, in_row_q, in_col_q);
	assign emit_nxt = fits(nxt_row, nxt_col, in_row_q, in_col_q);

	assign job_push = (state_q == F_GEN) && emit_cur && !queue_full;

	always_comb begin
		job.row        = bmf_pkg::ROW_W'(out_row_q);
		job.col        = bmf_pkg::COL_W'(out_col_q);
		job.slot       = bmf_pkg::SLOT_W'(out_slot_q);
		job.run_last   = !emit_nxt;
		job.frame_last = (out_row_q == OR_W'(HEIGHT - 1)) && row_wrap;
		wr.we          = accept;
		wr.slot        = bmf_pkg::SLOT_W'(in_slot_q);
		wr.addr        = bmf_pkg::COL_W'(in_col_q);
		wr.data        = pix_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_ACCEPT;
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
		end else begin
			case (state_q)
				F_ACCEPT: begin
					if (accept) begin
						state_q <= F_GEN;
					end
				end
				F_GEN: begin
					if (emit_cur) begin
						if (!queue_full) begin
							out_col_q <= nxt_col;
							out_row_q <= nxt_row;
							if (row_wrap) begin
								out_slot_q <= (out_slot_q == SW'(WINDOW - 1)) ? '0
									: out_slot_q + 1'b1;
							end
						end
					end else begin
						// no more results for this pixel: advance input position
						state_q <= F_ACCEPT;
						if (in_col_q == C_W'(WIDTH - 1)) begin
							in_col_q <= '0;
							if (in_row_q == IR_W'(HEIGHT - 1)) begin
								in_row_q   <= '0;
								in_slot_q  <= '0;
								out_row_q  <= '0;
								out_col_q  <= '0;
								out_slot_q <= '0;
							end else begin
								in_row_q  <= in_row_q + 1'b1;
								in_slot_q <= (in_slot_q == SW'(WINDOW - 1)) ? '0
									: in_slot_q + 1'b1;
							end
						end else begin
							in_col_q <= in_col_q + 1'b1;
						end
					end
				end
				default: state_q <= F_ACCEPT;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/bmf_back.sv]
`default_nettype none
module bmf_back #(
	parameter int WIDTH  = bmf_pkg::DEF_WIDTH,
	parameter int HEIGHT = bmf_pkg::DEF_HEIGHT,
	parameter int WINDOW = bmf_pkg::DEF_WINDOW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bmf_pkg::job_t             head,
	input  logic                      queue_empty,
	output logic                      pop,
	output logic                      busy,
	output logic [bmf_pkg::COL_W-1:0] raddr,
	input  logic [bmf_pkg::PIX_W-1:0] rdata [WINDOW],
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [bmf_pkg::PIX_W-1:0] m_tdata,
	output logic                      m_tlast,
	output logic                      m_tuser
);

	localparam int HALF   = WINDOW / 2;
	localparam int AREA   = WINDOW * WINDOW;
	localparam int SUM_W  = $clog2(AREA * 255 + 1);
	localparam int DIV_S  = 24;
	localparam int DIV_M  = ((1 << DIV_S) + AREA - 1) / AREA;
	localparam int M_W    = $clog2(DIV_M + 1);
	localparam int DC_W   = $clog2(WINDOW + 1);
	localparam int RSUM_W = $clog2(WINDOW * 255 + 1);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_READ = 4'b0010,
		B_DIV  = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t                   state_q;
	bmf_pkg::job_t             job_q;
	logic [DC_W-1:0]           dc_q;
	logic                      rd_vld_s1;
	logic [SUM_W-1:0]          sum_q;
	logic [bmf_pkg::PIX_W-1:0] res_q;
	logic                      last_q, flast_q;

	logic [bmf_pkg::COL_W:0]   cpos;
	logic                      col_ok;
	logic [RSUM_W-1:0]         col_sum;
	logic [SUM_W+M_W-1:0]      prod;

	assign pop  = (state_q == B_IDLE) && !queue_empty;
	assign busy = (state_q == B_READ);

	assign cpos   = {1'b0, job_q.col} + (bmf_pkg::COL_W+1)'(dc_q);
	assign col_ok = (cpos >= (bmf_pkg::COL_W+1)'(HALF))
		&& (cpos < (bmf_pkg::COL_W+1)'(WIDTH + HALF));
	assign raddr  = bmf_pkg::COL_W'(cpos - (bmf_pkg::COL_W+1)'(HALF));

	// sum one column of the window across the row slots
	always_comb begin
		logic [bmf_pkg::ROW_W:0]    rp;
		logic [bmf_pkg::SLOT_W+1:0] t;
		col_sum = '0;
		for (int dr = 0; dr < WINDOW; dr++) begin
			rp = {1'b0, job_q.row} + (bmf_pkg::ROW_W+1)'(dr);
			t  = (bmf_pkg::SLOT_W+2)'(job_q.slot) + (bmf_pkg::SLOT_W+2)'(dr + WINDOW - HALF);
			if (t >= (bmf_pkg::SLOT_W+2)'(WINDOW)) begin
				t = t - (bmf_pkg::SLOT_W+2)'(WINDOW);
			end
			if (t >= (bmf_pkg::SLOT_W+2)'(WINDOW)) begin
				t = t - (bmf_pkg::SLOT_W+2)'(WINDOW);
			end
			if ((rp >= (bmf_pkg::ROW_W+1)'(HALF))
					&& (rp < (bmf_pkg::ROW_W+1)'(HEIGHT + HALF))) begin
				col_sum = col_sum + RSUM_W'(rdata[t[$clog2(WINDOW)-1:0]]);
			end
		end
	end

	// divide by the window area as multiply by reciprocal
	assign prod = SUM_W'(sum_q) * M_W'(DIV_M);

	assign m_tvalid = (state_q == B_OUT);
	assign m_tdata  = res_q;
	assign m_tlast  = last_q;
	assign m_tuser  = flast_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (state_q == B_IDLE) begin
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(col_sum);
		end
		if (state_q == B_DIV) begin
			res_q   <= bmf_pkg::PIX_W'(prod >> DIV_S);
			last_q  <= job_q.run_last;
			flast_q <= job_q.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			dc_q      <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == B_READ) && (dc_q < DC_W'(WINDOW)) && col_ok;
			case (state_q)
				B_IDLE: begin
					dc_q <= '0;
					if (pop) begin
						state_q <= B_READ;
					end
				end
				B_READ: begin
					// the last column read lands in the cycle after it is issued
					if (dc_q == DC_W'(WINDOW)) begin
						state_q <= B_DIV;
					end else begin
						dc_q <= dc_q + 1'b1;
					end
				end
				B_DIV: begin
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (m_tready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_pop_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == B_READ))
		else $error("popped job did not start reading");

	a_div_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |=> m_tvalid)
		else $error("division result not presented");

	a_acc_only_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == B_READ))
		else $error("accumulate without a read");

	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !pop)
		else $error("job popped while reading");

endmodule
`default_nettype wire

[rtl/box_mean_filter_5x5_top.sv]
// box mean filter, zero padded, over a WIDTH x HEIGHT frame of 8-bit pixels
// input stream s_axis: one pixel per request in raster order, no framing
// output stream m_axis: smoothed pixels in raster order; tlast marks the last
// result caused by one input pixel, tuser marks the final pixel of the frame
// an input pixel that completes no window gives no output; row ends and the
// last pixel of the frame give a burst of results
// the front end accepts a pixel, then schedules its completed results one by
// one, pausing while the job queue is full; the back end takes one result at
// a time, one line store read per window column (WINDOW rams in parallel)
// the front end accepts a pixel only when the job queue is empty and the back
// end is not reading the line store; a result waiting on tready does not
// block the next pixel
// reset clears all position counters; the line store needs no clearing
// when m_axis stalls, the back end holds its result and the queue fills,
// then the front end stops taking pixels
`default_nettype none
module box_mean_filter_5x5_top #(
	parameter int WIDTH  = bmf_pkg::DEF_WIDTH,
	parameter int HEIGHT = bmf_pkg::DEF_HEIGHT,
	parameter int WINDOW = bmf_pkg::DEF_WINDOW
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] pixel
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] smoothed
	output logic            m_axis_tlast,
	output logic            m_axis_tuser    // [0] frame_last
);

	bmf_pkg::job_t             q_in, q_out;
	bmf_pkg::wr_t              wr;
	logic                      q_push, q_pop, q_empty, q_full, back_busy;
	logic [bmf_pkg::COL_W-1:0] raddr;
	logic [bmf_pkg::PIX_W-1:0] rdata [WINDOW];

	bmf_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT), .WINDOW(WINDOW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (s_axis_tvalid),
		.pix_ready  (s_axis_tready),
		.pix_data   (s_axis_tdata),
		.back_busy  (back_busy),
		.queue_empty(q_empty),
		.queue_full (q_full),
		.job        (q_in),
		.job_push   (q_push),
		.wr         (wr)
	);

	bmf_queue #(.DEPTH(bmf_pkg::QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.pop   (q_pop),
		.dout  (q_out),
		.empty (q_empty),
		.full  (q_full)
	);

	for (genvar s = 0; s < WINDOW; s++) begin : g_line
		bmf_ram #(.DATA_W(bmf_pkg::PIX_W), .DEPTH(bmf_pkg::ROW_DEPTH)) u_ram (
			.clk  (clk),
			.we   (wr.we && (wr.slot == bmf_pkg::SLOT_W'(s))),
			.waddr(wr.addr),
			.wdata(wr.data),
			.raddr(raddr),
			.rdata(rdata[s])
		);
	end

	bmf_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT), .WINDOW(WINDOW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_out),
		.queue_empty(q_empty),
		.pop        (q_pop),
		.busy       (back_busy),
		.raddr      (raddr),
		.rdata      (rdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tlast    (m_axis_tlast),
		.m_tuser    (m_axis_tuser)
	);

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
	logic [7:0] smoothed;
	logic       run_last;
	logic       frame_last;
} mean_px_t;

class box_mean_board;
	int width, height, win;
	logic [7:0] frame_px[4096][32];
	int in_row, in_col, out_row, out_col;
	mean_px_t pending[$];
	int errors;

	function new(int w, int h, int k);
		width = w;
		height = h;
		win = k;
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
		errors = 0;
	endfunction

	function logic [7:0] window_avg(int r, int c);
		int sum, rr, cc, half;
		sum = 0;
		half = win / 2;
		for (int dr = 0; dr < win; dr++) begin
			rr = r - half + dr;
			if (rr < 0 || rr >= height) continue;
			for (int dc = 0; dc < win; dc++) begin
				cc = c - half + dc;
				if (cc < 0 || cc >= width) continue;
				sum += frame_px[rr][cc];
			end
		end
		return 8'(sum / (win * win));
	endfunction

	// one pixel request accepted: queue the outputs it completes
	function void note_pixel(logic [7:0] px);
		int ahead, nr, nc, n;
		mean_px_t e;
		ahead = win - 1 - win / 2;
		n = 0;
		frame_px[in_row][in_col] = px;
		while (out_row < height) begin
			nr = (out_row + ahead > height - 1) ? height - 1 : out_row + ahead;
			nc = (out_col + ahead > width - 1) ? width - 1 : out_col + ahead;
			if (!(nr < in_row || (nr == in_row && nc <= in_col))) break;
			e.smoothed = window_avg(out_row, out_col);
			e.run_last = 1'b0;
			e.frame_last = (out_row == height - 1 && out_col == width - 1);
			pending.push_back(e);
			n++;
			out_col++;
			if (out_col >= width) begin
				out_col = 0;
				out_row++;
			end
		end
		if (n > 0) pending[pending.size() - 1].run_last = 1'b1;
		in_col++;
		if (in_col >= width) begin
			in_col = 0;
			in_row++;
			if (in_row >= height) begin
				in_row = 0;
				out_row = 0;
				out_col = 0;
			end
		end
	endfunction

	function void check_result(logic [7:0] d, logic l, logic u);
		mean_px_t e;
		if (pending.size() == 0) begin
			$error("unexpected result smoothed=%0d", d);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (d !== e.smoothed) begin
			$error("smoothed: expected %0d, actual %0d", e.smoothed, d);
			errors++;
		end
		if (l !== e.run_last) begin
			$error("run_last: expected %0d, actual %0d", e.run_last, l);
			errors++;
		end
		if (u !== e.frame_last) begin
			$error("frame_last: expected %0d, actual %0d", e.frame_last, u);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int W = bmf_pkg::DEF_WIDTH;
	localparam int H = bmf_pkg::DEF_HEIGHT;
	localparam int K = bmf_pkg::DEF_WINDOW;
	localparam int N_DIRECT = 2 * W * H;
	localparam int N_RANDOM = 128;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       m_axis_tuser;

	box_mean_board board;
	bit stim_done;
	int out_wait;

	box_mean_filter_5x5_top #(.WIDTH(W), .HEIGHT(H), .WINDOW(K)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// idle draw of 0 in bursts, else 0..4
	function automatic int idle_draw(bit burst);
		if (burst) return 0;
		return $urandom_range(0, 4);
	endfunction

	task automatic send_pixel(logic [7:0] px, bit burst);
		int gap;
		gap = idle_draw(burst);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		board.note_pixel(px);
	endtask

	// result side: random stall after each result until the stimulus is done
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b1;
			out_wait = 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			out_wait = stim_done ? 0 : $urandom_range(0, 4);
			m_axis_tready <= (out_wait == 0);
		end else if (!m_axis_tready) begin
			out_wait--;
			if (out_wait <= 0 || stim_done) m_axis_tready <= 1'b1;
		end
	end

	initial begin
		logic [7:0] px;
		bit burst;
		board = new(W, H, K);
		stim_done = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed frames: all-max, then pixels alternating between 0 and max
		for (int i = 0; i < N_DIRECT; i++) begin
			if (i < W * H) px = 8'hFF;
			else px = ((i % 2) == 1) ? 8'hFF : 8'h00;
			send_pixel(px, 1'b1);
		end
		burst = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if ((i % 40) == 0) burst = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 5))
				0: px = 8'h00;
				1: px = 8'hFF;
				default: px = 8'($urandom);
			endcase
			send_pixel(px, burst);
		end
		// close the last frame so every output is flushed
		while (board.in_row != 0 || board.in_col != 0) send_pixel(8'($urandom), 1'b0);
		s_axis_tvalid <= 1'b0;
		stim_done = 1'b1;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0) $display("box_mean_filter_5x5_top regression: pass");
		else $display("box_mean_filter_5x5_top regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("box_mean_filter_5x5_top regression: fail");
		$finish;
	end
endmodule

`default_nettype wire
